/* sv/subpixel_splat_accumulate_core_macros.svh */
// ----------------------------------------------------------------------------
// subpixel_splat_accumulate_core_macros.svh
// Assertion macros used by the checker file of the splat core.
// ----------------------------------------------------------------------------
`ifndef SUBPIXEL_SPLAT_ACCUMULATE_CORE_MACROS_SVH
`define SUBPIXEL_SPLAT_ACCUMULATE_CORE_MACROS_SVH

// same-cycle implication
`define SSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("splat core check failed");

// next-cycle implication
`define SSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("splat core check failed");

`endif

/* sv/ssa_pkg.sv */
// ----------------------------------------------------------------------------
// ssa_pkg
// Types, codes and helper functions of the subpixel splat core.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam logic FUNC_SPLAT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam int SLOT_W = 3;
  // splat touches four pixels: issue on slots 0..3, last write-back on slot 4
  localparam logic [SLOT_W-1:0] SLOT_PIXELS     = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_LAST_SPLAT = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_LAST_READ  = 3'd1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              clear_en;
    logic              load;
    logic              access;
    logic [SLOT_W-1:0] slot;
    logic              deliver;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_read;
    logic out_busy;
  } sts_t;

  // bilinear weight (a*b + a + b) >> 8, always fits 8 bits
  function automatic logic [7:0] weight(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = 16'(a) * 16'(b) + 16'(a) + 16'(b);
    return p[15:8];
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] base, input logic [7:0] add);
    logic [8:0] s;
    s = {1'b0, base} + {1'b0, add};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

/* sv/ssa_ctrl.sv */
// ----------------------------------------------------------------------------
// ssa_ctrl
// Sequencer: clearing pass, item load, per-pixel access slots, result hand-off.
// ----------------------------------------------------------------------------
module ssa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ssa_pkg::sts_t   sts,
  output ssa_pkg::cmd_t   cmd
);

  ssa_pkg::state_t state, state_next;
  logic [ssa_pkg::SLOT_W-1:0] slot;
  logic last_slot;

  assign last_slot = sts.is_read ? (slot == ssa_pkg::SLOT_LAST_READ)
                                 : (slot == ssa_pkg::SLOT_LAST_SPLAT);

  always_comb begin
    state_next = state;
    unique case (state)
      ssa_pkg::ST_CLEAR:  if (sts.clear_done) state_next = ssa_pkg::ST_IDLE;
      ssa_pkg::ST_IDLE:   if (in_valid) state_next = ssa_pkg::ST_ACCESS;
      ssa_pkg::ST_ACCESS: if (last_slot) state_next = ssa_pkg::ST_FINISH;
      ssa_pkg::ST_FINISH: if (!sts.out_busy) state_next = ssa_pkg::ST_IDLE;
      default:            state_next = ssa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.slot     = slot;
    in_stall     = 1'b1;
    unique case (state)
      ssa_pkg::ST_CLEAR:  cmd.clear_en = 1'b1;
      ssa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ssa_pkg::ST_ACCESS: cmd.access = 1'b1;
      ssa_pkg::ST_FINISH: cmd.deliver = !sts.out_busy;
      default:            cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssa_pkg::ST_CLEAR;
      slot  <= '0;
    end else begin
      state <= state_next;
      if (state == ssa_pkg::ST_ACCESS) begin
        slot <= slot + 1'b1;
      end else begin
        slot <= '0;
      end
    end
  end

endmodule

/* sv/ssa_datapath.sv */
// ----------------------------------------------------------------------------
// ssa_datapath
// Item registers, weight unit, frame memory with read-modify-write path,
// and the result register.
// ----------------------------------------------------------------------------
module ssa_datapath #(
  parameter int COLUMNS = 32,
  parameter int ROWS    = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  ssa_pkg::cmd_t cmd,
  output ssa_pkg::sts_t sts,
  input  logic          func,
  input  logic [12:0]   pos_x,
  input  logic [11:0]   pos_y,
  input  logic [7:0]    color_red,
  input  logic [7:0]    color_green,
  input  logic [7:0]    color_blue,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic          clipped
);

  localparam int PIXELS = COLUMNS * ROWS;
  localparam int AW     = $clog2(PIXELS);
  localparam logic [8:0] COLS_L = 9'(COLUMNS);
  localparam logic [8:0] ROWS_L = 9'(ROWS);

  // latched item
  logic        func_q;
  logic [4:0]  col_q;
  logic [3:0]  row_q;
  logic [7:0]  fx_q, fy_q;
  logic [7:0]  cr_q, cg_q, cb_q;

  // result under construction
  logic [7:0]  res_r, res_g, res_b;
  logic        res_clip;

  logic [23:0]   mem [PIXELS];
  logic [23:0]   rdata;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] prev_addr;
  logic          prev_in;
  logic [7:0]    wreg;

  logic          is_read;
  logic          dx, dy;
  logic [8:0]    c, r;
  logic          in_frame;
  logic [AW-1:0] addr;
  logic [7:0]    w;
  logic          issue;
  logic          wback;
  logic [15:0]   pr, pg, pb;
  logic          we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;

  assign is_read = (func_q == ssa_pkg::FUNC_READ);

  // neighbor of the current slot: bit 0 steps the column, bit 1 the row
  assign dx       = cmd.slot[0];
  assign dy       = cmd.slot[1];
  assign c        = 9'(col_q) + 9'(dx);
  assign r        = 9'(row_q) + 9'(dy);
  assign in_frame = (c < COLS_L) && (r < ROWS_L);
  assign addr     = AW'(32'(r) * COLUMNS + 32'(c));
  assign w        = ssa_pkg::weight(dx ? fx_q : ~fx_q, dy ? fy_q : ~fy_q);

  assign issue = cmd.access && (is_read ? (cmd.slot == '0)
                                        : (cmd.slot < ssa_pkg::SLOT_PIXELS));
  assign wback = cmd.access && (cmd.slot != '0) && prev_in;

  assign pr = 16'(cr_q) * 16'(wreg);
  assign pg = 16'(cg_q) * 16'(wreg);
  assign pb = 16'(cb_q) * 16'(wreg);

  always_comb begin
    we    = 1'b0;
    waddr = prev_addr;
    wdata = '0;
    if (cmd.clear_en) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (wback) begin
      we = 1'b1;
      if (!is_read) begin
        wdata = {ssa_pkg::sat_add(rdata[23:16], pr[15:8]),
                 ssa_pkg::sat_add(rdata[15:8],  pg[15:8]),
                 ssa_pkg::sat_add(rdata[7:0],   pb[15:8])};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue && in_frame) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      col_q    <= pos_x[12:8];
      row_q    <= pos_y[11:8];
      fx_q     <= pos_x[7:0];
      fy_q     <= pos_y[7:0];
      cr_q     <= color_red;
      cg_q     <= color_green;
      cb_q     <= color_blue;
      res_r    <= '0;
      res_g    <= '0;
      res_b    <= '0;
      res_clip <= 1'b0;
    end else if (cmd.access) begin
      prev_in   <= issue && in_frame;
      prev_addr <= addr;
      wreg      <= w;
      // during a splat, a zero-weight neighbor off the frame is dropped silently
      if (issue && !in_frame && (is_read || (w != '0))) begin
        res_clip <= 1'b1;
      end
      if (wback && is_read) begin
        res_r <= rdata[23:16];
        res_g <= rdata[15:8];
        res_b <= rdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_red   <= res_r;
      out_green <= res_g;
      out_blue  <= res_b;
      clipped   <= res_clip;
    end
  end

  assign sts.clear_done = (clr_addr == AW'(PIXELS - 1));
  assign sts.is_read    = is_read;
  assign sts.out_busy   = out_valid && out_stall;

endmodule

/* sv/subpixel_splat_accumulate_core.sv */
// ----------------------------------------------------------------------------
// subpixel_splat_accumulate_core
// Anti-aliased point splat into an RGB frame store, with read-and-clear.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_stall  | func, pos_x, pos_y, color_*
//   out     | output    | out_valid / out_stall| out_red/green/blue, clipped
//
// Splat: one word at a time in five memory slots; each slot reads at most one
//   pixel and writes at most one back over a one-read one-write frame memory.
// Read: one word at a time (one read slot, one clear write-back slot).
// After reset a clearing pass writes COLUMNS*ROWS zeros, one pixel a cycle;
//   in_stall stays high meanwhile.
// A stalled result sits in the output register; the next word is taken
//   and worked on, and waits only to hand over its own result.
// ----------------------------------------------------------------------------
module subpixel_splat_accumulate_core #(
  parameter int COLUMNS = 32,
  parameter int ROWS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [12:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  color_red,
  input  logic [7:0]  color_green,
  input  logic [7:0]  color_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        clipped
);

  ssa_pkg::cmd_t cmd;
  ssa_pkg::sts_t sts;

  ssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssa_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (func),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .color_red   (color_red),
    .color_green (color_green),
    .color_blue  (color_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .clipped     (clipped)
  );

endmodule

/* sv/ssa_checker.sv */
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level checks of the splat core, bound to the top level.
// ----------------------------------------------------------------------------
`include "subpixel_splat_accumulate_core_macros.svh"

module ssa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       clipped
);

  // clearing pass holds off input right after reset
  `SSA_ASSERT_NOW(a_clear_after_reset, clk, rst, $fell(rst), in_stall)

  // one word in flight: a taken word blocks the next cycle
  `SSA_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)

  // clipped results never carry color
  `SSA_ASSERT_NOW(a_clip_no_color, clk, rst, out_valid && clipped, (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0))

  `SSA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(clipped))

endmodule

bind subpixel_splat_accumulate_core ssa_checker u_ssa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .clipped   (clipped)
);
